### hdl/sqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_pkg
// shared types and codes for the stack / queue engine
// ----------------------------------------------------------------------------
package sqe_pkg;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_SWAP = 3'd2,
        OP_PEEK = 3'd3,
        OP_DUMP = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SHORT = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SWAP = 2'd2,
        S_DUMP = 2'd3
    } state_t;

endpackage

### hdl/sqe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe channel interfaces
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface sqe_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface sqe_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data_value;
    logic               has_value;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, output data_value, output has_value, output status,
                    output last, input ready);
    modport sink   (input valid, input data_value, input has_value, input status,
                    input last, output ready);
endinterface

### hdl/stack_queue_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_queue_engine_top
// bounded word store acting as a stack or queue, held in one synchronous ram
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------------
//  req      | in  | operation, push_value
//  rsp      | out | data_value, has_value, status, last
//  queue_mode_we / queue_mode_wdata: single-bit mode register write
//
//  one request at a time: accept in idle, then the execute step; swap adds a
//  second step for the second of its two ram writes on the single write port;
//  dump adds a walk step with one ram read per element
//  reset clears the top pointer, count, mode, state and response valid; ram contents are left as they are
//  a stalled response holds the engine in its current step, the ram read
//  address is kept so the read data stays valid across the stall
//
module stack_queue_engine_top #(
    parameter int DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    sqe_req_if.sink       req,
    sqe_rsp_if.source     rsp,
    input  logic          queue_mode_we,
    input  logic          queue_mode_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // pointer helpers, wrap at DEPTH
    function automatic logic [AW-1:0] ptr_down(input logic [AW-1:0] p);
        ptr_down = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_up(input logic [AW-1:0] p);
        ptr_up = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // element ram
    logic signed [31:0] mem_store [DEPTH];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic signed [31:0] rd_data_reg;

    // control state
    sqe_pkg::state_t    state_reg, state_next;
    logic [AW-1:0]      top_reg, top_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               mode_reg;

    // current item
    logic [2:0]         op_reg, op_next;
    logic signed [31:0] val_reg, val_next;

    // dump walk
    logic [AW-1:0]      dptr_reg, dptr_next;
    logic [CW-1:0]      cnt_reg, cnt_next;

    // response register
    logic               out_valid_reg;
    logic signed [31:0] out_data_reg;
    logic               out_has_reg;
    sqe_pkg::status_t   out_status_reg;
    logic               out_last_reg;

    // emit request from the datapath
    logic               emit;
    logic signed [31:0] emit_data;
    logic               emit_has;
    sqe_pkg::status_t   emit_status;
    logic               emit_last;

    logic               req_fire;
    logic               out_free;
    logic               is_full;
    logic               is_empty;
    logic               is_short;
    logic               dump_last;
    logic [CW:0]        qsum;
    logic [AW-1:0]      qaddr;

    assign req.ready  = (state_reg == sqe_pkg::S_IDLE);
    assign req_fire   = req.valid && req.ready;
    // slot is free when empty or being drained this cycle
    assign out_free   = !out_valid_reg || rsp.ready;

    assign is_full    = (count_reg == CW'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign is_short   = (count_reg < CW'(2));
    assign dump_last  = (cnt_reg == count_reg - CW'(1));

    // bottom slot for queue push: top - count, wrapped
    always_comb
    begin
        qsum = (CW+1)'(top_reg) - (CW+1)'(count_reg);
        if (qsum[CW])
        begin
            qsum = qsum + (CW+1)'(DEPTH);
        end
        qaddr = qsum[AW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sqe_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = sqe_pkg::S_EXEC;
                end
            end
            sqe_pkg::S_EXEC:
            begin
                if (op_reg == sqe_pkg::OP_SWAP && !is_short)
                begin
                    state_next = sqe_pkg::S_SWAP;
                end
                else if (op_reg == sqe_pkg::OP_DUMP && !is_empty)
                begin
                    state_next = sqe_pkg::S_DUMP;
                end
                else if (out_free)
                begin
                    state_next = sqe_pkg::S_IDLE;
                end
            end
            sqe_pkg::S_SWAP:
            begin
                if (out_free)
                begin
                    state_next = sqe_pkg::S_IDLE;
                end
            end
            sqe_pkg::S_DUMP:
            begin
                if (out_free && dump_last)
                begin
                    state_next = sqe_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sqe_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and emit decisions
    always_comb
    begin
        top_next    = top_reg;
        count_next  = count_reg;
        dptr_next   = dptr_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        mem_we      = 1'b0;
        mem_waddr   = top_reg;
        mem_wdata   = val_reg;
        rd_addr     = top_reg;
        rd_en       = 1'b1;
        emit        = 1'b0;
        emit_data   = '0;
        emit_has    = 1'b0;
        emit_status = sqe_pkg::ST_OK;
        emit_last   = 1'b1;

        case (state_reg)
            sqe_pkg::S_IDLE:
            begin
                // read the top now so it is ready in the execute step
                if (req_fire)
                begin
                    op_next  = req.operation;
                    val_next = req.push_value;
                end
            end
            sqe_pkg::S_EXEC:
            begin
                case (op_reg)
                    sqe_pkg::OP_PUSH:
                    begin
                        emit = out_free;
                        if (is_full)
                        begin
                            emit_status = sqe_pkg::ST_FULL;
                        end
                        else if (out_free)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (is_empty)
                            begin
                                mem_waddr = top_reg;
                            end
                            else if (!mode_reg)
                            begin
                                mem_waddr = ptr_up(top_reg);
                                top_next  = ptr_up(top_reg);
                            end
                            else
                            begin
                                mem_waddr = qaddr;
                            end
                        end
                    end
                    sqe_pkg::OP_POP:
                    begin
                        emit = out_free;
                        if (is_empty)
                        begin
                            emit_status = sqe_pkg::ST_EMPTY;
                        end
                        else if (out_free)
                        begin
                            count_next = count_reg - CW'(1);
                            if (count_reg != CW'(1))
                            begin
                                top_next = ptr_down(top_reg);
                            end
                        end
                    end
                    sqe_pkg::OP_SWAP:
                    begin
                        rd_addr = ptr_down(top_reg);
                        if (is_short)
                        begin
                            emit        = out_free;
                            emit_status = sqe_pkg::ST_SHORT;
                        end
                        else
                        begin
                            // old lower word is read while the top word lands on it
                            mem_we    = 1'b1;
                            mem_waddr = ptr_down(top_reg);
                            mem_wdata = rd_data_reg;
                        end
                    end
                    sqe_pkg::OP_PEEK:
                    begin
                        emit = out_free;
                        if (is_empty)
                        begin
                            emit_status = sqe_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            emit_data = rd_data_reg;
                            emit_has  = 1'b1;
                        end
                    end
                    sqe_pkg::OP_DUMP:
                    begin
                        if (is_empty)
                        begin
                            emit        = out_free;
                            emit_status = sqe_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            dptr_next = top_reg;
                            cnt_next  = '0;
                        end
                    end
                    default:
                    begin
                        emit = out_free;
                    end
                endcase
            end
            sqe_pkg::S_SWAP:
            begin
                // hold the old lower word and put it on top
                rd_en     = 1'b0;
                mem_we    = 1'b1;
                mem_waddr = top_reg;
                mem_wdata = rd_data_reg;
                emit      = out_free;
            end
            sqe_pkg::S_DUMP:
            begin
                rd_addr = dptr_reg;
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_data = rd_data_reg;
                    emit_has  = 1'b1;
                    emit_last = dump_last;
                    cnt_next  = cnt_reg + CW'(1);
                    dptr_next = ptr_down(dptr_reg);
                    rd_addr   = ptr_down(dptr_reg);
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // element ram, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_store[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_store[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sqe_pkg::S_IDLE;
            top_reg       <= '0;
            count_reg     <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            count_reg <= count_next;
            if (queue_mode_we)
            begin
                mode_reg <= queue_mode_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        val_reg  <= val_next;
        dptr_reg <= dptr_next;
        cnt_reg  <= cnt_next;
        if (emit)
        begin
            out_data_reg   <= emit_data;
            out_has_reg    <= emit_has;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.data_value = out_data_reg;
    assign rsp.has_value  = out_has_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.last       = out_last_reg;

`ifndef NO_ASSERTIONS
    // occupancy never passes the bound
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
    else $error("element count above depth");

    // top pointer stays inside the ring for any depth
    assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= AW'(DEPTH - 1))
    else $error("top pointer out of range");

    // count moves by at most one per request
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1)))
    else $error("element count jumped");

    // swap second step only runs with two or more elements
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sqe_pkg::S_SWAP) |-> (count_reg >= CW'(2)))
    else $error("swap with too few elements");

    // dump walk never runs past the element count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sqe_pkg::S_DUMP) |-> (cnt_reg < count_reg))
    else $error("dump index past count");
`endif

endmodule
